FILE: hw/rtl/flgr_pkg.sv
// ----------------------------------------------------------------------------
// flgr_pkg: shared types and constants of the flanger delay effect
// Register indices, register reset values, fixed field widths, sequencer
// states.
// ----------------------------------------------------------------------------
package flgr_pkg;

  localparam int DELAY_W   = 11;  // min_delay, lfo_depth
  localparam int PERIOD_W  = 20;  // lfo_period, phase_offset, sweep phase
  localparam int GAIN_W    = 16;  // feedback_gain, wet_gain
  localparam int CFG_W     = 20;  // widest register
  localparam int CFG_IDX_W = 3;

  localparam int WET_SHIFT = 12;  // wet_gain is Q4.12
  localparam int FB_SHIFT  = 14;  // feedback_gain is Q2.14

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_DELAY     = 3'd0,
    CFG_LFO_DEPTH     = 3'd1,
    CFG_LFO_PERIOD    = 3'd2,
    CFG_PHASE_OFFSET  = 3'd3,
    CFG_FEEDBACK_GAIN = 3'd4,
    CFG_WET_GAIN      = 3'd5
  } cfg_index_t;

  localparam logic [DELAY_W-1:0]  MIN_DELAY_RST     = 11'd0;
  localparam logic [DELAY_W-1:0]  LFO_DEPTH_RST     = 11'd192;
  localparam logic [PERIOD_W-1:0] LFO_PERIOD_RST    = 20'd96000;
  localparam logic [PERIOD_W-1:0] PHASE_OFFSET_RST  = 20'd0;
  localparam logic [GAIN_W-1:0]   FEEDBACK_GAIN_RST = 16'd0;
  localparam logic [GAIN_W-1:0]   WET_GAIN_RST      = 16'd4096;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,     // phase reduced modulo period
    ST_MUL,     // sweep numerator
    ST_TRI_GO,  // launch sweep divide
    ST_TRI,     // sweep divide running
    ST_DELAY,   // delay, clamp, history check
    ST_RD_B,    // read near tap
    ST_RD_A,    // read far tap, take near tap
    ST_GET_A,   // take far tap
    ST_PROD_A,
    ST_PROD_B,
    ST_TAP,
    ST_WET,
    ST_FBK,
    ST_FIN      // mix, write back, hand over result
  } state_t;

endpackage

FILE: hw/rtl/flgr_ram.sv
// ----------------------------------------------------------------------------
// flgr_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module flgr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/flgr_div.sv
// ----------------------------------------------------------------------------
// flgr_div: restoring divider, one quotient bit per cycle
// Dividend's upper DIV_W bits must be below the divisor. done pulses once
// the last step is registered; quotient and remainder hold until next start.
// ----------------------------------------------------------------------------
module flgr_div #(
  parameter int QUO_W = 20,
  parameter int DIV_W = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [DIV_W+QUO_W-1:0] dividend,
  input  logic [DIV_W-1:0]       divisor,
  output logic [QUO_W-1:0]       quotient,
  output logic [DIV_W-1:0]       remainder,
  output logic                   done
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [DIV_W-1:0] rem;
  logic [QUO_W-1:0] sh;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DIV_W:0]   cat;
  logic [DIV_W:0]   diff;
  logic             qbit;

  always_comb begin
    cat  = {rem, sh[QUO_W-1]};
    diff = cat - {1'b0, divisor};
    qbit = ~diff[DIV_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUO_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[QUO_W +: DIV_W];
      sh  <= dividend[QUO_W-1:0];
    end else if (busy) begin
      rem <= qbit ? diff[DIV_W-1:0] : cat[DIV_W-1:0];
      sh  <= {sh[QUO_W-2:0], qbit};
    end
  end

  assign quotient  = sh;
  assign remainder = rem;

endmodule

FILE: hw/rtl/flanger_delay_effect_unit.sv
// ----------------------------------------------------------------------------
// flanger_delay_effect_unit: flanger with triangle sweep and feedback
// Mono samples go into a delay ring; an interpolated tap at a swept delay is
// mixed into the output and fed back into the stored sample.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel in_valid/in_stall carries one sample_in per item; output
//    channel out_valid/out_stall carries sample_out and wet_active.
//  - Registers are written through cfg_write/cfg_index/cfg_data while the
//    block is idle; every valid write restarts the sweep at phase_offset.
//    Indices beyond the list are ignored.
//  - One item at a time. With lfo_period >= 2 the shared one-bit-per-cycle
//    divider runs once to reduce the phase and once for the sweep value;
//    with a shorter period the sweep is skipped. When the tap is mixed, two
//    reads follow from the ring's single read port; when it passes dry,
//    they are left out.
//  - The result waits in an output register; the next item is accepted as
//    soon as the sequencer is back in idle, which it enters as out_valid
//    rises, so the next item can be taken while the result still waits.
//    Processing stalls only at the final step while the previous result has
//    not been taken.
//  - Reset (synchronous) clears the sequencer, pointers, history count and
//    output valid, and loads register defaults. The ring itself is not
//    cleared: the history count keeps unwritten entries from being read.
// ----------------------------------------------------------------------------
module flanger_delay_effect_unit #(
  parameter int DELAY_DEPTH = 2048,
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_write,
  input  logic [flgr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [flgr_pkg::CFG_W-1:0]    cfg_data,
  // input items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  // result items
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          wet_active
);

  import flgr_pkg::*;

  localparam int ADDR_W = $clog2(DELAY_DEPTH);
  localparam int SEEN_W = $clog2(DELAY_DEPTH + 1);
  // sweep value stays below 1.5 * lfo_depth * 2^F
  localparam int QUO_W  = (FRAC_BITS + 12 > PERIOD_W) ? FRAC_BITS + 12 : PERIOD_W;
  localparam int DVD_W  = PERIOD_W + QUO_W;
  localparam int DQ_W   = 18 + FRAC_BITS;
  localparam int FW     = FRAC_BITS + 1;
  localparam int P_W    = SAMPLE_BITS + FW + 1;
  localparam int M_W    = SAMPLE_BITS + GAIN_W + 1;
  localparam int PROD_W = DELAY_W + PERIOD_W;

  localparam logic [DQ_W-1:0]   DMAX    = DQ_W'(DELAY_DEPTH - 1) << FRAC_BITS;
  localparam logic [DQ_W-1:0]   FMASK   = (DQ_W'(1) << FRAC_BITS) - DQ_W'(1);
  localparam logic [ADDR_W:0]   DEPTH_X = (ADDR_W + 1)'(DELAY_DEPTH);
  localparam logic signed [M_W:0] SMAX  =
    $signed({{(M_W + 2 - SAMPLE_BITS){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}});
  localparam logic signed [M_W:0] SMIN  = -SMAX - (M_W + 1)'(1);

  // registers
  logic [DELAY_W-1:0]  min_delay, lfo_depth;
  logic [PERIOD_W-1:0] lfo_period, phase_offset, lfo_phase;
  logic signed [GAIN_W-1:0] feedback_gain;
  logic [GAIN_W-1:0]   wet_gain;

  state_t state, state_next;

  logic [ADDR_W-1:0]          wp;
  logic [SEEN_W-1:0]          seen;
  logic signed [SAMPLE_BITS-1:0] x, a_smp, b_smp, tap;
  logic [PERIOD_W-1:0]        p;
  logic [DVD_W-1:0]           num;
  logic [QUO_W-1:0]           tri_part;
  logic [ADDR_W-1:0]          wsteps;
  logic [FW-1:0]              frac;
  logic                       wet_ok;
  logic signed [P_W-1:0]      pa, pb;
  logic signed [M_W-1:0]      mw, mf;

  // combinational
  logic                 accept, period_ok, out_free, done_fin;
  logic                 div_start, div_done, rd_far, ram_we;
  logic [DVD_W-1:0]     div_dvd;
  logic [QUO_W-1:0]     div_quo;
  logic [PERIOD_W-1:0]  div_rem;
  logic [PERIOD_W-1:0]  qsel;
  logic [PROD_W-1:0]    prod;
  logic [DVD_W-1:0]     num_next;
  logic [DQ_W-1:0]      dq, dq_c, seen_q;
  logic                 wet_ok_next;
  logic [ADDR_W:0]      steps, rdiff;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic [FW-1:0]        wgt;
  logic signed [P_W:0]  tsum, tsh;
  logic signed [M_W:0]  x_ext, y_sum, s_sum;
  logic signed [SAMPLE_BITS-1:0] y_val, store_val;
  logic [PERIOD_W:0]    p_inc;
  logic [PERIOD_W-1:0]  phase_next;

  function automatic logic signed [M_W:0] trunc_shift(input logic signed [M_W-1:0] v,
                                                       input int sh);
    logic signed [M_W:0] ve;
    logic signed [M_W:0] bias;
    ve   = {v[M_W-1], v};
    bias = $signed(((M_W + 1)'(1) << sh) - (M_W + 1)'(1));
    if (v[M_W-1]) begin
      ve = ve + bias;   // round towards zero
    end
    return ve >>> sh;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [M_W:0] v);
    logic signed [M_W:0] r;
    r = v;
    if (v > SMAX) begin
      r = SMAX;
    end else if (v < SMIN) begin
      r = SMIN;
    end
    return r[SAMPLE_BITS-1:0];
  endfunction

  assign accept    = in_valid && !in_stall;
  assign period_ok = lfo_period >= PERIOD_W'(2);
  assign out_free  = !out_valid || !out_stall;
  assign done_fin  = (state == ST_FIN) && out_free;
  assign in_stall  = (state != ST_IDLE);

  // ---------------- shared divider ----------------
  flgr_div #(.QUO_W(QUO_W), .DIV_W(PERIOD_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (lfo_period),
    .quotient (div_quo),
    .remainder(div_rem),
    .done     (div_done)
  );

  // ---------------- delay ring ----------------
  flgr_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DELAY_DEPTH)) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp),
    .wdata(store_val),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = period_ok ? ST_MOD : ST_DELAY;
      ST_MOD:    if (div_done) state_next = ST_MUL;
      ST_MUL:    state_next = ST_TRI_GO;
      ST_TRI_GO: state_next = ST_TRI;
      ST_TRI:    if (div_done) state_next = ST_DELAY;
      ST_DELAY:  state_next = wet_ok_next ? ST_RD_B : ST_FIN;
      ST_RD_B:   state_next = ST_RD_A;
      ST_RD_A:   state_next = ST_GET_A;
      ST_GET_A:  state_next = ST_PROD_A;
      ST_PROD_A: state_next = ST_PROD_B;
      ST_PROD_B: state_next = ST_TAP;
      ST_TAP:    state_next = ST_WET;
      ST_WET:    state_next = ST_FBK;
      ST_FBK:    state_next = ST_FIN;
      ST_FIN:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // ---------------- sequencer: outputs ----------------
  always_comb begin
    div_start = 1'b0;
    div_dvd   = num;
    rd_far    = 1'b0;
    ram_we    = 1'b0;
    case (state)
      ST_IDLE: begin
        div_start = accept && period_ok;
        div_dvd   = DVD_W'(lfo_phase);
      end
      ST_TRI_GO: div_start = 1'b1;
      ST_RD_A:   rd_far    = 1'b1;
      ST_FIN:    ram_we    = out_free;
      default: begin
      end
    endcase
  end

  // ---------------- datapath ----------------
  always_comb begin
    // triangle: fold the phase about half a period
    qsel     = (p < (lfo_period >> 1)) ? p : lfo_period - p;
    prod     = PROD_W'(lfo_depth) * PROD_W'(qsel);
    num_next = DVD_W'(prod) << (FRAC_BITS + 1);

    dq          = (DQ_W'(min_delay) << FRAC_BITS) + DQ_W'(tri_part);
    dq_c        = (dq > DMAX) ? DMAX : dq;
    seen_q      = DQ_W'(seen) << FRAC_BITS;
    wet_ok_next = seen_q >= dq_c;

    // ring address w or w+1 samples back from the write pointer
    steps     = rd_far ? ({1'b0, wsteps} + (ADDR_W + 1)'(1)) : {1'b0, wsteps};
    rdiff     = {1'b0, wp} - steps;
    ram_raddr = rdiff[ADDR_W] ? ADDR_W'(rdiff + DEPTH_X) : rdiff[ADDR_W-1:0];

    wgt  = (FW'(1) << FRAC_BITS) - frac;
    tsum = {pa[P_W-1], pa} + {pb[P_W-1], pb};
    tsh  = tsum >>> FRAC_BITS;

    x_ext     = {{(M_W + 1 - SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
    y_sum     = x_ext + trunc_shift(mw, WET_SHIFT);
    s_sum     = x_ext + trunc_shift(mf, FB_SHIFT);
    y_val     = wet_ok ? sat(y_sum) : x;
    store_val = wet_ok ? sat(s_sum) : x;

    p_inc      = {1'b0, p} + (PERIOD_W + 1)'(1);
    phase_next = !period_ok ? '0 :
                 (p_inc >= {1'b0, lfo_period}) ? '0 : p_inc[PERIOD_W-1:0];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      min_delay     <= MIN_DELAY_RST;
      lfo_depth     <= LFO_DEPTH_RST;
      lfo_period    <= LFO_PERIOD_RST;
      phase_offset  <= PHASE_OFFSET_RST;
      feedback_gain <= FEEDBACK_GAIN_RST;
      wet_gain      <= WET_GAIN_RST;
      lfo_phase     <= PHASE_OFFSET_RST;
      wp            <= '0;
      seen          <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        case (cfg_index_t'(cfg_index))
          CFG_MIN_DELAY: begin
            min_delay <= cfg_data[DELAY_W-1:0];
            lfo_phase <= phase_offset;
          end
          CFG_LFO_DEPTH: begin
            lfo_depth <= cfg_data[DELAY_W-1:0];
            lfo_phase <= phase_offset;
          end
          CFG_LFO_PERIOD: begin
            lfo_period <= cfg_data[PERIOD_W-1:0];
            lfo_phase  <= phase_offset;
          end
          CFG_PHASE_OFFSET: begin
            phase_offset <= cfg_data[PERIOD_W-1:0];
            lfo_phase    <= cfg_data[PERIOD_W-1:0];
          end
          CFG_FEEDBACK_GAIN: begin
            feedback_gain <= $signed(cfg_data[GAIN_W-1:0]);
            lfo_phase     <= phase_offset;
          end
          CFG_WET_GAIN: begin
            wet_gain  <= cfg_data[GAIN_W-1:0];
            lfo_phase <= phase_offset;
          end
          default: begin
          end
        endcase
      end else if (done_fin) begin
        lfo_phase <= phase_next;
      end

      if (done_fin) begin
        wp <= (wp == ADDR_W'(DELAY_DEPTH - 1)) ? '0 : wp + ADDR_W'(1);
        if (seen < SEEN_W'(DELAY_DEPTH)) begin
          seen <= seen + SEEN_W'(1);
        end
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          x        <= sample_in;
          p        <= '0;
          tri_part <= '0;
        end
      end
      ST_MOD:    if (div_done) p <= div_rem;
      ST_MUL:    num <= num_next;
      ST_TRI:    if (div_done) tri_part <= div_quo;
      ST_DELAY: begin
        wet_ok <= wet_ok_next;
        wsteps <= ADDR_W'(dq_c >> FRAC_BITS);
        frac   <= FW'(dq_c & FMASK);
      end
      // the newest sample is not in the ring yet
      ST_RD_A:   b_smp <= (wsteps == '0) ? x : $signed(ram_rdata);
      ST_GET_A:  a_smp <= (frac != '0) ? $signed(ram_rdata) : '0;
      ST_PROD_A: pa <= a_smp * $signed({1'b0, frac});
      ST_PROD_B: pb <= b_smp * $signed({1'b0, wgt});
      ST_TAP:    tap <= tsh[SAMPLE_BITS-1:0];
      ST_WET:    mw <= $signed({1'b0, wet_gain}) * tap;
      ST_FBK:    mf <= feedback_gain * tap;
      ST_FIN: begin
        if (out_free) begin
          sample_out <= y_val;
          wet_active <= wet_ok;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hw/rtl/flgr_checker.sv
// ----------------------------------------------------------------------------
// flgr_checker: port-level checks for the flanger delay effect
// Handshake hold rules, reset behaviour and one-item-at-a-time sequencing.
// ----------------------------------------------------------------------------
module flgr_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [SAMPLE_BITS-1:0] sample_out,
  input logic                   wet_active
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(sample_out) && $stable(wet_active))
    else $error("result changed while stalled");

  // reset leaves no result pending and the input open
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("bad state after reset");

  // an accepted item occupies the block
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after accepting an item");

  // a new result is only produced by a busy block
  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in work");

endmodule

bind flanger_delay_effect_unit flgr_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_flgr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .sample_out(sample_out),
  .wet_active(wet_active)
);

FILE: verif/flanger_delay_effect_unit_test.sv
// ----------------------------------------------------------------------------
// flanger_delay_effect_unit_test: self-checking bench for the flanger unit
// Feeds mono samples through the valid/stall input channel under a series of
// register settings, predicts every result with an in-bench copy of the delay
// ring, sweep and mixer, and checks each result item in order.
// ----------------------------------------------------------------------------
module flanger_delay_effect_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import flgr_pkg::*;

  localparam int RING_DEPTH     = 2048;
  localparam int RING_AW        = 11;
  localparam int FRAC_Q         = 8;
  localparam int SMP_W          = 16;
  localparam int SETTLE_CYCLES  = 80;   // beyond the longest item
  localparam int HOLD_LEN       = 700;  // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 4000; // idle cycles before giving up
  localparam int RAND_PHASES    = 12;
  localparam int PHASE_ITEMS    = 80;

  // indices past the register list; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam longint unsigned DLY_MAX = longint'(RING_DEPTH - 1) << FRAC_Q;

  typedef struct packed {
    logic signed [SMP_W-1:0] smp;
    logic                    wet;
  } mix_t;

  // --------------------------------------------------------------------------
  // DUT and its ports
  // --------------------------------------------------------------------------
  logic                    clk;
  logic                    rst;
  logic                    cfg_write;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]        cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [SMP_W-1:0] sample_in;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [SMP_W-1:0] sample_out;
  logic                    wet_active;

  flanger_delay_effect_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .wet_active (wet_active)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  logic signed [SMP_W-1:0] feed_q[$];   // samples waiting to be offered
  mix_t                    mix_due[$];  // predicted results, oldest first
  int                      idle_pct;    // idling chance per cycle, both sides
  int                      fault_cnt;
  int                      taken_cnt;
  int                      hold_left;
  int                      stuck_cycles;
  mix_t                    got;

  // Shadow of the block: registers, ring, pointers, sweep phase
  logic [DELAY_W-1:0]         min_dly_r;
  logic [DELAY_W-1:0]         depth_r;
  logic [PERIOD_W-1:0]        period_r;
  logic [PERIOD_W-1:0]        offset_r;
  logic signed [GAIN_W-1:0]   fbk_r;
  logic [GAIN_W-1:0]          wet_r;
  logic signed [SMP_W-1:0]    echo_ring [RING_DEPTH];
  logic [RING_AW-1:0]         ring_wp;
  int unsigned                hist_cnt;
  logic [PERIOD_W-1:0]        sweep_phase;

  function automatic logic signed [SMP_W-1:0] clip16(input longint signed v);
    if (v > 32767)  return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[SMP_W-1:0];
  endfunction

  // Register write as the block sees it; only listed indices restart the sweep
  function automatic void reg_apply(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] data);
    case (idx)
      CFG_MIN_DELAY:     min_dly_r = data[DELAY_W-1:0];
      CFG_LFO_DEPTH:     depth_r   = data[DELAY_W-1:0];
      CFG_LFO_PERIOD:    period_r  = data[PERIOD_W-1:0];
      CFG_PHASE_OFFSET:  offset_r  = data[PERIOD_W-1:0];
      CFG_FEEDBACK_GAIN: fbk_r     = data[GAIN_W-1:0];
      CFG_WET_GAIN:      wet_r     = data[GAIN_W-1:0];
      default:           return;
    endcase
    sweep_phase = offset_r;
  endfunction

  // One sample through the flanger: sweep, clamp, interpolated tap, mix,
  // feedback into the ring; queues the expected result.
  function automatic void flange_predict(input logic signed [SMP_W-1:0] x);
    longint unsigned per;
    longint unsigned ph;
    longint unsigned sweep;
    longint unsigned dq;
    longint unsigned w;
    longint signed   f;
    longint signed   a;
    longint signed   b;
    longint signed   tap;
    logic [RING_AW-1:0] idx_b;
    logic [RING_AW-1:0] idx_a;
    mix_t res;
    per   = period_r;
    ph    = 0;
    sweep = 0;
    if (per >= 2) begin
      ph = sweep_phase % per;
      if (ph < per / 2)
        sweep = ((longint'(depth_r) * 2 * ph) << FRAC_Q) / per;
      else
        sweep = ((longint'(depth_r) * 2 * (per - ph)) << FRAC_Q) / per;
    end
    dq = (longint'(min_dly_r) << FRAC_Q) + sweep;
    if (dq > DLY_MAX) dq = DLY_MAX;

    echo_ring[ring_wp] = x;
    res.smp = x;
    res.wet = 1'b0;
    // dry until enough history exists for the current delay
    if ((longint'(hist_cnt) << FRAC_Q) >= dq) begin
      w     = dq >> FRAC_Q;
      f     = dq & ((1 << FRAC_Q) - 1);
      idx_b = ring_wp - w[RING_AW-1:0];
      idx_a = idx_b - 1'b1;
      b     = echo_ring[idx_b];
      a     = (f != 0) ? longint'(echo_ring[idx_a]) : 0;
      tap   = (a * f + b * ((1 << FRAC_Q) - f)) >>> FRAC_Q;  // floor
      // signed divides truncate toward zero
      res.smp = clip16(longint'(x) + (longint'(wet_r) * tap) / (1 << WET_SHIFT));
      echo_ring[ring_wp] =
        clip16(longint'(x) + (longint'(fbk_r) * tap) / (1 << FB_SHIFT));
      res.wet = 1'b1;
    end

    ring_wp = ring_wp + 1'b1;
    if (hist_cnt < RING_DEPTH) hist_cnt++;
    if (per >= 2) sweep_phase = (ph + 1 >= per) ? '0 : PERIOD_W'(ph + 1);
    else          sweep_phase = '0;
    mix_due.push_back(res);
  endfunction

  task automatic flag_fault(input string msg);
    fault_cnt++;
    if (fault_cnt <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued samples, predicts on each accepted item
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        flange_predict(sample_in);
      end
      // a stalled item stays put; otherwise pick the next one or idle
      if (!in_valid || !in_stall) begin
        if (feed_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_valid  <= 1'b1;
          sample_in <= feed_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks results, drives the receiver's stall
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (mix_due.size() == 0) begin
          flag_fault($sformatf("result with nothing expected: out=%0d wet=%0b",
                               sample_out, wet_active));
        end else begin
          got = mix_due.pop_front();
          if (sample_out !== got.smp || wet_active !== got.wet)
            flag_fault($sformatf("mismatch: expected out=%0d wet=%0b, got out=%0d wet=%0b",
                                 got.smp, got.wet, sample_out, wet_active));
        end
        taken_cnt++;
        // long hold-offs: the block fills and must stall its input
        if (taken_cnt == 300 || taken_cnt == 700) hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: nothing moving on either channel for too long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration and stimulus
  // --------------------------------------------------------------------------

  // Register write; bits above the register's width carry junk on purpose.
  // Back-to-back calls keep cfg_write high; cfg_close lowers it.
  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx,
                         input logic [CFG_W-1:0] val, input int width);
    logic [CFG_W-1:0] junk;
    junk = $urandom;
    junk = (width >= CFG_W) ? '0 : (junk << width);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= junk | val;
    reg_apply(idx, junk | val);
  endtask

  task automatic cfg_close();
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_all(input int md, input int dp, input int per,
                         input int off, input int fb, input int wg);
    cfg_put(CFG_MIN_DELAY,     CFG_W'(md), DELAY_W);
    cfg_put(CFG_LFO_DEPTH,     CFG_W'(dp), DELAY_W);
    cfg_put(CFG_LFO_PERIOD,    CFG_W'(per), PERIOD_W);
    cfg_put(CFG_FEEDBACK_GAIN, CFG_W'(fb & 16'hffff), GAIN_W);
    cfg_put(CFG_WET_GAIN,      CFG_W'(wg), GAIN_W);
    cfg_put(CFG_PHASE_OFFSET,  CFG_W'(off), PERIOD_W);
    cfg_close();
  endtask

  // Block idle: everything offered, accepted and checked, then some margin
  task automatic settle();
    while (feed_q.size() != 0 || in_valid || mix_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SMP_W-1:0] draw_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return SMP_W'($signed($urandom_range(0, 128)) - 64);
      default: return SMP_W'($urandom);
    endcase
  endfunction

  function automatic int pick_delay();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return $urandom_range(0, 24);
      2:       return $urandom_range(0, 2047);
      default: return $urandom_range(2046, 2047);
    endcase
  endfunction

  function automatic int pick_gain();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 16'hffff;
      2:       return 16'h8000;
      default: return $urandom_range(0, 16'hffff);
    endcase
  endfunction

  initial begin
    int md;
    int dp;
    int per;
    int off;
    clk       = 1'b0;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    sample_in = '0;
    out_stall = 1'b0;
    idle_pct  = 29;
    fault_cnt = 0;
    taken_cnt = 0;
    hold_left = 0;
    stuck_cycles = 0;

    // shadow reset: register defaults, empty history
    min_dly_r   = MIN_DELAY_RST;
    depth_r     = LFO_DEPTH_RST;
    period_r    = LFO_PERIOD_RST;
    offset_r    = PHASE_OFFSET_RST;
    fbk_r       = FEEDBACK_GAIN_RST;
    wet_r       = WET_GAIN_RST;
    ring_wp     = '0;
    hist_cnt    = 0;
    sweep_phase = PHASE_OFFSET_RST;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: zero delay at phase 0 taps the current sample
    feed_q.push_back(16'sh7fff);
    feed_q.push_back(16'sh8000);
    feed_q.push_back(16'sh0000);
    feed_q.push_back(-16'sd1);
    feed_q.push_back(16'sh0001);
    feed_q.push_back(16'sh5555);
    feed_q.push_back(16'shaaaa);
    settle();

    // period zero, widest gains, phase at the top of its field: saturation
    set_all(3, 2047, 0, 20'hfffff, 16'h8000, 16'hffff);
    feed_q.push_back(16'sh7fff);
    feed_q.push_back(16'sh7fff);
    feed_q.push_back(16'sh8000);
    feed_q.push_back(16'sh8000);
    feed_q.push_back(16'sh7fff);
    settle();

    // period one: sweep off, full positive feedback, no wet
    set_all(0, 1000, 1, 5, 16'h7fff, 0);
    feed_q.push_back(16'sh4000);
    feed_q.push_back(16'shc000);
    feed_q.push_back(16'sh7fff);
    settle();

    // delay beyond the ring is clamped; phase offset above the period
    set_all(2046, 2047, 4, 20'hfffff, 16'h2000, 16'h1000);
    feed_q.push_back(16'sh1234);
    feed_q.push_back(16'shedcb);
    settle();

    // writes past the register list must leave the sweep running on
    set_all(1, 3, 8, 3, 16'h1000, 16'h3000);
    feed_q.push_back(16'sh0100);
    feed_q.push_back(16'sh0200);
    feed_q.push_back(16'sh0300);
    settle();
    cfg_put(CFG_SPARE_LO, CFG_W'($urandom), CFG_W);
    cfg_put(CFG_SPARE_HI, CFG_W'($urandom), CFG_W);
    cfg_close();
    feed_q.push_back(16'sh0400);
    feed_q.push_back(16'sh0500);
    feed_q.push_back(16'sh0600);
    settle();

    // random phases; history grows over the run so later phases reach
    // longer delays, the last one delays at or near the clamp, still short of full history
    for (int ph_i = 0; ph_i < RAND_PHASES; ph_i++) begin
      md = pick_delay();
      dp = pick_delay();
      case ($urandom_range(0, 3))
        0:       per = $urandom_range(0, 8);
        1:       per = $urandom_range(2, 60);
        2:       per = $urandom_range(61, 4000);
        default: per = $urandom_range(4001, 20'hfffff);
      endcase
      if ($urandom_range(0, 3) == 0) off = $urandom_range(0, 20'hfffff);
      else                           off = $urandom_range(0, (per > 1) ? per - 1 : 0);
      if (ph_i == RAND_PHASES - 1) begin
        md = 2046;
        dp = 2046;
      end
      // one phase runs flat out on both sides
      idle_pct = (ph_i == 2) ? 0 : 29;
      set_all(md, dp, per, off, pick_gain(), pick_gain());
      repeat (PHASE_ITEMS) feed_q.push_back(draw_sample());
      settle();
    end

    if (fault_cnt == 0 && mix_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
